/* sv/fcmi_pkg.sv */
// fcmi_pkg: shared types, palette tables and register codes of the false-color map interpolator
// no dependencies; imported by fcmi_div_pipe, false_color_map_interpolator_core, pixel_map_checker and tb
`timescale 1ns / 1ps

package fcmi_pkg;

	// classification of a sample, decided at the entry stage
	typedef enum logic [2:0] {
		KIND_DATA   = 3'd0,
		KIND_BELOW  = 3'd1,
		KIND_ABOVE  = 3'd2,
		KIND_NODATA = 3'd3,
		KIND_EMPTY  = 3'd4
	} kind_t;

	// sideband that rides along with the quotient through the divider
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  pal;
	} meta_t;

	typedef enum logic [1:0] {
		REG_RANGE_LOW  = 2'd0,
		REG_RANGE_HIGH = 2'd1,
		REG_PALETTE    = 2'd2
	} reg_idx_t;

	localparam logic [1:0] PAL_HEAT    = 2'd0;
	localparam logic [1:0] PAL_TERRAIN = 2'd1;
	localparam logic [1:0] PAL_GRAY    = 2'd2;

	localparam logic [7:0] GRAY_LEVEL = 8'd128;
	localparam logic [7:0] ALPHA_ON   = 8'hFF;
	localparam logic [7:0] ALPHA_OFF  = 8'h00;

	// number of segments in a palette; unused code falls back to heat
	function automatic logic [2:0] seg_count(input logic [1:0] pal);
		logic [2:0] n;
		case (pal)
			PAL_TERRAIN: n = 3'd3;
			PAL_GRAY:    n = 3'd1;
			default:     n = 3'd5;
		endcase
		return n;
	endfunction

	// palette entry as {red, green, blue}
	function automatic logic [23:0] pal_rgb(input logic [1:0] pal, input logic [2:0] idx);
		logic [23:0] c;
		c = 24'h000000;
		case (pal)
			PAL_TERRAIN: begin
				case (idx)
					3'd0:    c = {8'd0,   8'd120, 8'd0};
					3'd1:    c = {8'd160, 8'd120, 8'd40};
					3'd2:    c = {8'd180, 8'd180, 8'd180};
					3'd3:    c = {8'd255, 8'd255, 8'd255};
					default: c = 24'h000000;
				endcase
			end
			PAL_GRAY: begin
				case (idx)
					3'd1:    c = {8'd255, 8'd255, 8'd255};
					default: c = 24'h000000;
				endcase
			end
			default: begin
				case (idx)
					3'd0:    c = {8'd0,   8'd0,   8'd255};
					3'd1:    c = {8'd0,   8'd150, 8'd255};
					3'd2:    c = {8'd0,   8'd255, 8'd150};
					3'd3:    c = {8'd255, 8'd255, 8'd0};
					3'd4:    c = {8'd255, 8'd120, 8'd0};
					3'd5:    c = {8'd180, 8'd0,   8'd0};
					default: c = 24'h000000;
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

/* sv/fcmi_if.sv */
// fcmi_sample_if and fcmi_color_if: valid/ready stream channels of the interpolator
// no dependencies
`timescale 1ns / 1ps

interface fcmi_sample_if #(
	parameter int SAMPLE_WIDTH = 32
) ();
	logic                    valid;
	logic                    ready;
	logic [SAMPLE_WIDTH-1:0] sample;
	logic                    sample_valid;

	modport source (output valid, output sample, output sample_valid, input ready);
	modport sink   (input valid, input sample, input sample_valid, output ready);
endinterface

interface fcmi_color_if ();
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source (output valid, output red, output green, output blue, output alpha,
		input ready);
	modport sink   (input valid, input red, input green, input blue, input alpha,
		output ready);
endinterface

/* sv/fcmi_div_pipe.sv */
// fcmi_div_pipe: pipelined restoring divider, one quotient bit per stage
// computes floor(rem * 2^FRACTION_BITS / den) for rem < den; uses fcmi_pkg
`timescale 1ns / 1ps

module fcmi_div_pipe #(
	parameter int SAMPLE_WIDTH  = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [SAMPLE_WIDTH-1:0]   in_rem,
	input  fcmi_pkg::meta_t           in_meta,
	input  logic [SAMPLE_WIDTH-1:0]   den,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [FRACTION_BITS-1:0]  out_quo,
	output fcmi_pkg::meta_t           out_meta
);
	import fcmi_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int F  = FRACTION_BITS;

	logic [SW-1:0] rem_s   [F];
	logic [F-1:0]  quo_s   [F];
	meta_t         meta_s  [F];
	logic [F-1:0]  valid_s;

	logic [SW-1:0] src_rem [F];
	logic [F-1:0]  src_quo [F];
	meta_t         src_meta[F];
	logic [F-1:0]  src_valid;
	logic [F-1:0]  rdy;
	logic [F-1:0]  nxt_rdy;

	genvar k;
	generate
		for (k = 0; k < F; k++) begin : g_stage
			logic [SW:0]   shifted;
			logic [SW+1:0] diff;
			logic          ge;

			if (k == 0) begin : g_first
				assign src_rem[k]   = in_rem;
				assign src_quo[k]   = '0;
				assign src_meta[k]  = in_meta;
				assign src_valid[k] = in_valid;
			end else begin : g_next
				assign src_rem[k]   = rem_s[k-1];
				assign src_quo[k]   = quo_s[k-1];
				assign src_meta[k]  = meta_s[k-1];
				assign src_valid[k] = valid_s[k-1];
			end

			if (k == F - 1) begin : g_last
				assign nxt_rdy[k] = out_ready;
			end else begin : g_mid
				assign nxt_rdy[k] = rdy[k+1];
			end

			assign rdy[k]  = ~valid_s[k] | nxt_rdy[k];
			assign shifted = {src_rem[k], 1'b0};
			assign diff    = {1'b0, shifted} - {2'b00, den};
			assign ge      = ~diff[SW+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					valid_s[k] <= src_valid[k];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && src_valid[k]) begin
					rem_s[k]  <= ge ? diff[SW-1:0] : shifted[SW-1:0];
					quo_s[k]  <= {src_quo[k][F-2:0], ge};
					meta_s[k] <= src_meta[k];
				end
			end
		end
	endgenerate

	assign in_ready  = rdy[0];
	assign out_valid = valid_s[F-1];
	assign out_quo   = quo_s[F-1];
	assign out_meta  = meta_s[F-1];

	// a stalled stage keeps its partial quotient
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_quo)))
		else $error("divider output changed while stalled");

	a_div_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s[0] |-> in_ready)
		else $error("divider refused a beat with its first stage empty");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_meta.kind == KIND_DATA) |-> (rem_s[F-1] < den))
		else $error("divider remainder not below divisor");

endmodule

/* sv/false_color_map_interpolator_core.sv */
// false_color_map_interpolator_core: maps a signed raster sample to an RGBA pixel
// uses fcmi_pkg, fcmi_sample_if / fcmi_color_if and fcmi_div_pipe
//
// usage: samples (sample, sample_valid) enter on the samples channel, one pixel
// (red, green, blue, alpha) leaves on the pixels channel per sample, in order.
// the window range_low..range_high and the palette are set over the APB port
// (register 0 range_low, 1 range_high, 2 palette_select); the user must write them only
// while no beat is in flight, and the block itself does not enforce this.
// an accepted sample passes one entry stage, one divider stage per fraction bit,
// a scale stage, a multiply stage and the output register. throughput is one beat
// per cycle while pixels.ready stays high.
// nodata samples give transparent black, an empty window gives opaque gray.
// reset clears every stage's valid bit and loads the register reset values.
// when pixels.ready is low, stages fill up behind the output register and
// samples.ready drops only once the entry stage holds a beat that cannot move.
`timescale 1ns / 1ps

module false_color_map_interpolator_core #(
	parameter int SAMPLE_WIDTH  = 32,
	parameter int FRACTION_BITS = 16,
	localparam int APB_DW       = (SAMPLE_WIDTH > 32) ? 64 : 32,
	localparam int ADDR_LSB     = (SAMPLE_WIDTH > 32) ? 3 : 2,
	localparam int APB_AW       = ADDR_LSB + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	fcmi_sample_if.sink         samples,
	fcmi_color_if.source        pixels,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready
);
	import fcmi_pkg::*;

	localparam int SW     = SAMPLE_WIDTH;
	localparam int F      = FRACTION_BITS;
	localparam int SCL_W  = F + 3;
	localparam int PROD_W = F + 9;
	localparam int SUM_W  = F + 10;
	localparam logic [F:0]        FRAC_ONE = {1'b1, {F{1'b0}}};
	localparam logic [SUM_W-1:0]  HALF     = SUM_W'(FRAC_ONE >> 1);
	localparam logic [SW-1:0]     RANGE_HIGH_RST = SW'(32'd65535);

	// configuration registers
	logic [SW-1:0] range_low_q;
	logic [SW-1:0] range_high_q;
	logic [1:0]    palette_q;
	logic [SW-1:0] den_q;
	reg_idx_t      reg_idx;
	logic          cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1:ADDR_LSB]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= RANGE_HIGH_RST;
			palette_q    <= PAL_HEAT;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_RANGE_LOW:  range_low_q  <= pwdata[SW-1:0];
				REG_RANGE_HIGH: range_high_q <= pwdata[SW-1:0];
				REG_PALETTE:    palette_q    <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RANGE_LOW:  prdata = APB_DW'(range_low_q);
			REG_RANGE_HIGH: prdata = APB_DW'(range_high_q);
			REG_PALETTE:    prdata = APB_DW'(palette_q);
			default:        prdata = '0;
		endcase
	end

	// offset binary keeps signed order as unsigned order
	logic [SW-1:0] lo_b, hi_b, s_b;
	assign lo_b = {~range_low_q[SW-1], range_low_q[SW-2:0]};
	assign hi_b = {~range_high_q[SW-1], range_high_q[SW-2:0]};
	assign s_b  = {~samples.sample[SW-1], samples.sample[SW-2:0]};

	// divisor is registered, so it settles in the cycle after a write, before any beat can use it
	always_ff @(posedge clk) begin
		den_q <= hi_b - lo_b;
	end

	// entry stage
	logic          valid_s1;
	logic [SW-1:0] rem_s1;
	meta_t         meta_s1;
	logic          rdy_s1;
	logic          div_in_ready;
	kind_t         kind_in;

	always_comb begin
		if (!samples.sample_valid) begin
			kind_in = KIND_NODATA;
		end else if (hi_b <= lo_b) begin
			kind_in = KIND_EMPTY;
		end else if (s_b <= lo_b) begin
			kind_in = KIND_BELOW;
		end else if (s_b >= hi_b) begin
			kind_in = KIND_ABOVE;
		end else begin
			kind_in = KIND_DATA;
		end
	end

	assign rdy_s1        = ~valid_s1 | div_in_ready;
	assign samples.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && samples.valid) begin
			rem_s1        <= (kind_in == KIND_DATA) ? (s_b - lo_b) : '0;
			meta_s1.kind  <= kind_in;
			meta_s1.pal   <= (palette_q == 2'd3) ? PAL_HEAT : palette_q;
		end
	end

	// fraction, one bit per stage
	logic          div_valid;
	logic          rdy_sa;
	logic [F-1:0]  div_quo;
	meta_t         div_meta;

	fcmi_div_pipe #(
		.SAMPLE_WIDTH  (SW),
		.FRACTION_BITS (F)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (div_in_ready),
		.in_rem    (rem_s1),
		.in_meta   (meta_s1),
		.den       (den_q),
		.out_valid (div_valid),
		.out_ready (rdy_sa),
		.out_quo   (div_quo),
		.out_meta  (div_meta)
	);

	// scale stage: segment index and blend weight
	logic          valid_sa;
	logic [2:0]    idx_a_sa, idx_b_sa;
	logic [F-1:0]  t_sa;
	meta_t         meta_sa;
	logic          rdy_sb;
	logic [F:0]    frac;
	logic [SCL_W-1:0] scaled;
	logic [2:0]    nseg, idx_lo, idx_hi;

	always_comb begin
		case (div_meta.kind)
			KIND_ABOVE: frac = FRAC_ONE;
			KIND_DATA:  frac = {1'b0, div_quo};
			default:    frac = '0;
		endcase
		nseg   = seg_count(div_meta.pal);
		scaled = SCL_W'(frac) * SCL_W'(nseg);
		idx_lo = scaled[SCL_W-1:F];
		idx_hi = ((idx_lo + 3'd1) < nseg) ? (idx_lo + 3'd1) : nseg;
	end

	assign rdy_sa = ~valid_sa | rdy_sb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sa <= 1'b0;
		end else if (rdy_sa) begin
			valid_sa <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_sa && div_valid) begin
			idx_a_sa <= idx_lo;
			idx_b_sa <= idx_hi;
			t_sa     <= scaled[F-1:0];
			meta_sa  <= div_meta;
		end
	end

	// multiply stage: both ends of the segment, weighted per channel
	logic              valid_sb;
	logic [PROD_W-1:0] pa_sb [3];
	logic [PROD_W-1:0] pb_sb [3];
	kind_t             kind_sb;
	logic              rdy_out;
	logic [23:0]       col_a, col_b;
	logic [F:0]        w_a;

	assign col_a  = pal_rgb(meta_sa.pal, idx_a_sa);
	assign col_b  = pal_rgb(meta_sa.pal, idx_b_sa);
	assign w_a    = FRAC_ONE - {1'b0, t_sa};
	assign rdy_sb = ~valid_sb | rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sb <= 1'b0;
		end else if (rdy_sb) begin
			valid_sb <= valid_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_sb && valid_sa) begin
			for (int c = 0; c < 3; c++) begin
				pa_sb[c] <= PROD_W'(col_a[23-8*c -: 8]) * PROD_W'(w_a);
				pb_sb[c] <= PROD_W'(col_b[23-8*c -: 8]) * PROD_W'(t_sa);
			end
			kind_sb <= meta_sa.kind;
		end
	end

	// output register: round half up, then special cases
	logic [SUM_W-1:0] sum [3];
	logic [7:0]       chan [3];
	logic             valid_q;
	logic [7:0]       red_q, green_q, blue_q, alpha_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c]  = SUM_W'(pa_sb[c]) + SUM_W'(pb_sb[c]) + HALF;
			chan[c] = sum[c][F+7:F];
		end
	end

	assign rdy_out = ~valid_q | pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rdy_out) begin
			valid_q <= valid_sb;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && valid_sb) begin
			case (kind_sb)
				KIND_NODATA: begin
					red_q   <= 8'd0;
					green_q <= 8'd0;
					blue_q  <= 8'd0;
					alpha_q <= ALPHA_OFF;
				end
				KIND_EMPTY: begin
					red_q   <= GRAY_LEVEL;
					green_q <= GRAY_LEVEL;
					blue_q  <= GRAY_LEVEL;
					alpha_q <= ALPHA_ON;
				end
				default: begin
					red_q   <= chan[0];
					green_q <= chan[1];
					blue_q  <= chan[2];
					alpha_q <= ALPHA_ON;
				end
			endcase
		end
	end

	assign pixels.valid = valid_q;
	assign pixels.red   = red_q;
	assign pixels.green = green_q;
	assign pixels.blue  = blue_q;
	assign pixels.alpha = alpha_q;

	a_alpha_code: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid |-> (pixels.alpha == ALPHA_ON || pixels.alpha == ALPHA_OFF))
		else $error("alpha is neither opaque nor transparent");

	a_transparent_black: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.alpha == ALPHA_OFF) |->
			(pixels.red == 8'd0 && pixels.green == 8'd0 && pixels.blue == 8'd0))
		else $error("transparent pixel carries color");

	a_entry_load: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> valid_s1)
		else $error("accepted sample did not reach the entry stage");

	a_mult_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_sb && !rdy_out) |=> (valid_sb && $stable(pa_sb[0]) && $stable(pb_sb[2])))
		else $error("multiply stage lost a stalled beat");

endmodule

/* verif/fcmi_pixel_checker.sv */
// pixel_map_checker: watches the samples, pixels and apb channels of the interpolator,
// predicts each pixel from its own copy of the window and palette, and compares in order
// depends on fcmi_pkg and the fcmi_sample_if / fcmi_color_if interfaces
`timescale 1ns / 1ps

module pixel_map_checker #(
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	fcmi_sample_if      samples,
	fcmi_color_if       pixels,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          in_flight
);
	import fcmi_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	localparam longint unsigned FRAC_ONE  = 64'd1 << FRACTION_BITS;
	localparam longint unsigned FRAC_HALF = FRAC_ONE >> 1;

	localparam logic [23:0] HEAT_RGB [6] = '{24'h0000FF, 24'h0096FF, 24'h00FF96,
		24'hFFFF00, 24'hFF7800, 24'hB40000};
	localparam logic [23:0] TERRAIN_RGB [4] = '{24'h007800, 24'hA07828, 24'hB4B4B4,
		24'hFFFFFF};
	localparam logic [23:0] GRAY_RGB [2] = '{24'h000000, 24'hFFFFFF};

	logic signed [31:0] win_low;
	logic signed [31:0] win_high;
	logic [1:0]         pal_code;
	rgba_t              pixel_queue [$];
	int                 fail_count;

	assign mismatches = fail_count;

	function automatic logic [23:0] ramp_color(input logic [1:0] pal, input int unsigned idx);
		logic [23:0] c;
		case (pal)
			PAL_TERRAIN: c = TERRAIN_RGB[idx];
			PAL_GRAY:    c = GRAY_RGB[idx];
			default:     c = HEAT_RGB[idx];
		endcase
		return c;
	endfunction

	function automatic rgba_t predict_pixel(input logic [31:0] s, input logic ok);
		longint            lo_l;
		longint            hi_l;
		longint            s_l;
		longint unsigned   frac;
		longint unsigned   scaled;
		longint unsigned   w;
		longint unsigned   a;
		longint unsigned   b;
		int unsigned       segs;
		int unsigned       seg;
		int unsigned       nxt;
		logic [23:0]       ca;
		logic [23:0]       cb;
		logic [23:0]       mix;
		rgba_t             px;
		if (!ok) begin
			px = '{ALPHA_OFF, ALPHA_OFF, ALPHA_OFF, ALPHA_OFF};
			return px;
		end
		if (win_high <= win_low) begin
			px = '{GRAY_LEVEL, GRAY_LEVEL, GRAY_LEVEL, ALPHA_ON};
			return px;
		end
		lo_l = win_low;
		hi_l = win_high;
		s_l = longint'(signed'(s));
		if (s_l <= lo_l) begin
			frac = 0;
		end else if (s_l >= hi_l) begin
			frac = FRAC_ONE;
		end else begin
			frac = longint'((s_l - lo_l) << FRACTION_BITS) / longint'(hi_l - lo_l);
		end
		case (pal_code)
			PAL_TERRAIN: segs = 3;
			PAL_GRAY:    segs = 1;
			default:     segs = 5;
		endcase
		scaled = frac * segs;
		seg = int'(scaled >> FRACTION_BITS);
		w = scaled & (FRAC_ONE - 1);
		if (seg > segs) begin
			seg = segs;
		end
		nxt = (seg + 1 < segs) ? seg + 1 : segs;
		ca = ramp_color(pal_code, seg);
		cb = ramp_color(pal_code, nxt);
		for (int ch = 0; ch < 3; ch++) begin
			a = ca[23 - 8*ch -: 8];
			b = cb[23 - 8*ch -: 8];
			mix[23 - 8*ch -: 8] = 8'((a * (FRAC_ONE - w) + b * w + FRAC_HALF) >> FRACTION_BITS);
		end
		px = '{mix[23:16], mix[15:8], mix[7:0], ALPHA_ON};
		return px;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: pixel %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rgba_t want;
		if (!arst_n) begin
			win_low <= 32'sd0;
			win_high <= 32'sd65535;
			pal_code <= PAL_HEAT;
			pixel_queue.delete();
			fail_count = 0;
			in_flight <= 0;
		end else begin
			if (samples.valid && samples.ready) begin
				pixel_queue.push_back(predict_pixel(samples.sample, samples.sample_valid));
			end
			if (pixels.valid && pixels.ready) begin
				if (pixel_queue.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected pixel beat, expected none, got %0d/%0d/%0d/%0d",
						$time, pixels.red, pixels.green, pixels.blue, pixels.alpha);
				end else begin
					want = pixel_queue.pop_front();
					compare_field("red", want.red, pixels.red);
					compare_field("green", want.green, pixels.green);
					compare_field("blue", want.blue, pixels.blue);
					compare_field("alpha", want.alpha, pixels.alpha);
				end
			end
			// register writes only happen while idle, so they never race a sample
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_RANGE_LOW:  win_low <= pwdata;
					REG_RANGE_HIGH: win_high <= pwdata;
					REG_PALETTE:    pal_code <= pwdata[1:0];
					default: ;
				endcase
			end
			in_flight <= pixel_queue.size();
		end
	end

endmodule

/* verif/tb.sv */
// tb: stimulus and verdict for false_color_map_interpolator_core
// drives samples and apb writes, stalls the pixel side; pixel_map_checker does the checking
`timescale 1ns / 1ps

module tb;
	import fcmi_pkg::*;

	localparam int SW          = 32;
	localparam int FB          = 16;
	localparam int LATENCY     = FB + 4;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD   = 300;
	localparam int PHASES      = 14;
	localparam int PHASE_ITEMS = 107;
	localparam int PRESSURE_PH = 4;
	localparam logic [1:0] PAL_SPARE = 2'd3;
	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic [31:0] DIR_SAMPLE [16] = '{32'd0, 32'd65535, 32'd65534, 32'd1,
		32'd32767, 32'd32768, 32'd13107, 32'd26214, 32'd39321, 32'd52428, 32'hFFFF_FFFF,
		32'h8000_0000, 32'h7FFF_FFFF, 32'd65536, 32'd12345, 32'hFFFF_FFFF};
	localparam logic DIR_OK [16] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
		1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches;
	int          in_flight;
	int          hold_requests = 0;
	bit          src_calm = 1'b0;
	bit          sink_calm = 1'b0;
	logic signed [31:0] cur_low = 32'sd0;
	logic signed [31:0] cur_high = 32'sd65535;

	fcmi_sample_if #(.SAMPLE_WIDTH(SW)) samples ();
	fcmi_color_if pixels ();

	false_color_map_interpolator_core #(
		.SAMPLE_WIDTH(SW),
		.FRACTION_BITS(FB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.pixels(pixels),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	pixel_map_checker #(.FRACTION_BITS(FB)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.pixels(pixels),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.mismatches(mismatches),
		.in_flight(in_flight)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
	endfunction

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_window(input logic signed [31:0] lo, input logic signed [31:0] hi,
		input logic [1:0] pal);
		apb_write(REG_RANGE_LOW, lo);
		apb_write(REG_RANGE_HIGH, hi);
		apb_write(REG_PALETTE, {30'd0, pal});
		cur_low = lo;
		cur_high = hi;
	endtask

	task automatic push_sample(input logic [31:0] s, input logic ok);
		int gap;
		samples.valid <= 1'b1;
		samples.sample <= s;
		samples.sample_valid <= ok;
		do @(posedge clk); while (!samples.ready);
		gap = (src_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sample side until every pixel in flight has come out
	task automatic drain();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	task automatic pick_sample(output logic [31:0] s, output logic ok);
		longint          lo_l;
		longint          hi_l;
		longint unsigned rnd;
		int              r;
		lo_l = cur_low;
		hi_l = cur_high;
		ok = 1'b1;
		s = $urandom;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			ok = 1'b0;
		end else if (r < 16) begin
			case ($urandom_range(0, 3))
				0: s = cur_low;
				1: s = cur_high;
				2: s = cur_low - 1;
				default: s = cur_high + 1;
			endcase
		end else if (r < 20) begin
			s = $urandom_range(0, 1) ? S_MIN : S_MAX;
		end else if (r >= 26 && hi_l > lo_l) begin
			rnd = {$urandom, $urandom};
			s = 32'(lo_l + longint'(rnd % unsigned'(hi_l - lo_l + 1)));
		end
	endtask

	// pixel side: random stalls, calm stretches, and one long hold-off on request
	initial begin
		int hold_served;
		hold_served = 0;
		pixels.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_served != hold_requests) begin
				hold_served++;
				pixels.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (sink_calm || $urandom_range(0, 3) != 0) begin
				pixels.ready <= 1'b1;
				@(posedge clk);
			end else begin
				pixels.ready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("false_color_map_interpolator_core test failed");
		$finish;
	end

	initial begin
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic [1:0]         pal;
		logic [31:0]        s;
		logic               ok;
		samples.valid <= 1'b0;
		samples.sample <= '0;
		samples.sample_valid <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window 0..65535 on heat: ends, segment joints, outside, nodata
		for (int k = 0; k < 16; k++) begin
			push_sample(DIR_SAMPLE[k], DIR_OK[k]);
		end
		drain();
		// full signed window on the unused palette code
		set_window(S_MIN, S_MAX, PAL_SPARE);
		push_sample(32'd0, 1'b1);
		push_sample(S_MIN, 1'b1);
		push_sample(S_MAX, 1'b1);
		push_sample(32'h4000_0000, 1'b1);
		drain();
		set_window(32'sd7, 32'sd7, PAL_GRAY);
		push_sample(32'd7, 1'b1);
		push_sample(32'd7, 1'b0);
		drain();
		set_window(32'sd100, -32'sd100, PAL_TERRAIN);
		push_sample(32'd0, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			lo = $urandom;
			hi = lo + ($urandom >> $urandom_range(0, 31));
			pal = 2'($urandom_range(0, 3));
			case (ph)
				0: begin lo = 32'sd0; hi = 32'sd65535; pal = PAL_HEAT; end
				1: begin lo = S_MIN; hi = S_MAX; pal = PAL_TERRAIN; end
				2: begin hi = lo; pal = PAL_GRAY; end
				3: begin lo = S_MAX; hi = S_MIN; pal = PAL_HEAT; end
				5: begin lo = lo >>> 1; hi = lo + 1; pal = PAL_GRAY; end
				6: begin lo = lo >>> 1; hi = lo + 3; pal = PAL_TERRAIN; end
				7: begin lo = lo >>> 1; hi = lo + 5; pal = PAL_HEAT; end
				8: pal = PAL_SPARE;
				9: begin lo = S_MIN; hi = S_MIN + 1; pal = PAL_HEAT; end
				10: begin lo = S_MAX - 1; hi = S_MAX; pal = PAL_TERRAIN; end
				default: ;
			endcase
			drain();
			set_window(lo, hi, pal);
			src_calm <= (ph == PRESSURE_PH) || ($urandom_range(0, 3) == 0);
			sink_calm <= ($urandom_range(0, 3) == 0);
			if (ph == PRESSURE_PH) begin
				// back-to-back samples against a long pixel hold-off fill the pipe
				hold_requests <= hold_requests + 1;
			end
			@(posedge clk);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick_sample(s, ok);
				push_sample(s, ok);
			end
		end

		drain();
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && in_flight == 0) begin
			$display("false_color_map_interpolator_core test passed");
		end else begin
			$display("false_color_map_interpolator_core test failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/fcmi_pkg.sv
sv/fcmi_if.sv
sv/fcmi_div_pipe.sv
sv/false_color_map_interpolator_core.sv
verif/fcmi_pixel_checker.sv
verif/tb.sv
